/* rtl/scfr_pkg.sv */
// Shared types, constants and reset values for the sync/CRC16 frame receiver.
`default_nettype none

package scfr_pkg;

  // Reset values of the configuration registers
  localparam logic [7:0]  SYNC_FIRST_RESET    = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RESET   = 8'h55;
  localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd256;

  localparam int LENGTH_BITS_DEFAULT = 16;

  // CRC-16, MSB first, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Input queue between the front and the parser
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  // Number of header bytes replayed after a bad length
  localparam int REPLAY_BYTES = 4;
  localparam int REPLAY_BITS  = $clog2(REPLAY_BYTES);

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST    = 2'd0,
    CFG_SYNC_SECOND   = 2'd1,
    CFG_PAYLOAD_LIMIT = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_FIRST   = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRC_LO  = 3'd6,
    PH_CRC_HI  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] payload_limit;
  } cfg_t;

  // One queued byte with its sync classification
  typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_second;
  } rx_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        last;
    logic [31:0] good_count;
    logic [31:0] bad_count;
    logic [31:0] dropped_count;
  } result_t;

endpackage

`default_nettype wire

/* rtl/sync_crc16_frame_receiver.sv */
// Top level: sync-framed byte receiver with CRC-16 check, config registers and output ports.
// A result is registered after its byte has passed the input queue and then the parser.
// Throughput: one byte per cycle while the result consumer keeps up.
// A frame with a bad length makes the parser replay its four header bytes, taking nothing from the queue;
// the four-entry input queue absorbs that, then in_ready drops until it drains.
// Reset (rst, synchronous): parser hunts, counters cleared, CRC to its initial value, config to defaults.
`default_nettype none

module sync_crc16_frame_receiver #(
  parameter int LENGTH_BITS = scfr_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Config write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Byte request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  // Result request channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       command,
  output logic [7:0]       payload_byte,
  output logic [15:0]      payload_length,
  output logic             last,
  output logic [31:0]      good_count,
  output logic [31:0]      bad_count,
  output logic [31:0]      dropped_count
);

  scfr_pkg::cfg_t      cfg;
  scfr_pkg::rx_entry_t q_entry;
  scfr_pkg::result_t   out_res;
  logic                q_valid;
  logic                q_pop;

  // Config registers; an unused index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first    <= scfr_pkg::SYNC_FIRST_RESET;
      cfg.sync_second   <= scfr_pkg::SYNC_SECOND_RESET;
      cfg.payload_limit <= scfr_pkg::PAYLOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scfr_pkg::CFG_SYNC_FIRST:    cfg.sync_first    <= cfg_data[7:0];
        scfr_pkg::CFG_SYNC_SECOND:   cfg.sync_second   <= cfg_data[7:0];
        scfr_pkg::CFG_PAYLOAD_LIMIT: cfg.payload_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: take bytes, tag sync matches, buffer a few
  scfr_rx_queue u_rx_queue (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  // Back: parse frames, check CRC, hold the result until taken
  scfr_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind           = out_res.kind;
  assign command        = out_res.command;
  assign payload_byte   = out_res.payload_byte;
  assign payload_length = out_res.payload_length;
  assign last           = out_res.last;
  assign good_count     = out_res.good_count;
  assign bad_count      = out_res.bad_count;
  assign dropped_count  = out_res.dropped_count;

endmodule

`default_nettype wire

/* rtl/scfr_rx_queue.sv */
// Front part: accepts link bytes, tags sync matches, and queues them for the parser.
`default_nettype none

module scfr_rx_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire scfr_pkg::cfg_t       cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           rx_byte,
  output logic                      q_valid,
  output scfr_pkg::rx_entry_t       q_entry,
  input  wire logic                 q_pop
);

  scfr_pkg::rx_entry_t mem [scfr_pkg::QUEUE_DEPTH];
  logic [scfr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [scfr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [scfr_pkg::QUEUE_PTR_BITS:0]   count;
  logic push;
  logic pop;

  assign in_ready = (count != (scfr_pkg::QUEUE_PTR_BITS+1)'(scfr_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data:      rx_byte,
                       is_first:  (rx_byte == cfg.sync_first),
                       is_second: (rx_byte == cfg.sync_second)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/scfr_parser.sv */
// Back part: frame parser, CRC check, counters, header replay and result register.
`default_nettype none

module scfr_parser #(
  parameter int LENGTH_BITS = scfr_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire scfr_pkg::cfg_t      cfg,
  input  wire logic                q_valid,
  input  wire scfr_pkg::rx_entry_t q_entry,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output scfr_pkg::result_t        out_res
);

  localparam int REPLAY_BITS = scfr_pkg::REPLAY_BITS;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ scfr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  scfr_pkg::phase_t phase, phase_next;
  logic [7:0]  header_store [scfr_pkg::REPLAY_BYTES];
  logic [scfr_pkg::REPLAY_BITS-1:0] replay_index;
  logic        replay_active;
  logic [LENGTH_BITS-1:0] byte_counter, byte_counter_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic        skipping_flag, skipping_next;
  logic [31:0] good_frames, good_next;
  logic [31:0] bad_frames, bad_next;
  logic [31:0] dropped_runs, dropped_next;

  logic [7:0]  cur_byte;
  logic        cur_first;
  logic        cur_second;
  logic        take;
  logic        step;
  logic        do_drop;
  logic        clear_skip;
  logic        replay_start;
  logic        res_load;
  logic [15:0] len;
  logic [15:0] new_len;
  logic [15:0] crc_upd;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [3:0]  hdr_we;
  scfr_pkg::result_t res_next;

  // Replayed bytes come from the header store, otherwise from the queue
  assign cur_byte   = replay_active ? header_store[replay_index] : q_entry.data;
  assign cur_first  = replay_active ? (header_store[replay_index] == cfg.sync_first)
                                    : q_entry.is_first;
  assign cur_second = replay_active ? (header_store[replay_index] == cfg.sync_second)
                                    : q_entry.is_second;

  assign take  = !replay_active && q_valid && (!out_valid || out_ready);
  assign q_pop = take;
  assign step  = replay_active || take;

  assign len     = {header_store[3], header_store[2]};
  assign new_len = {cur_byte, header_store[2]};
  assign crc_upd = crc_byte(running_crc, cur_byte);
  assign cnt_inc = byte_counter + 1'b1;

  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    running_crc_next  = running_crc;
    crc_low_byte_next = crc_low_byte;
    good_next         = good_frames;
    bad_next          = bad_frames;
    do_drop           = 1'b0;
    clear_skip        = 1'b0;
    replay_start      = 1'b0;
    res_load          = 1'b0;
    hdr_we            = '0;
    res_next          = '0;
    res_next.command  = header_store[1];
    res_next.payload_length = len;

    if (step) begin
      case (phase)
        scfr_pkg::PH_HUNT: begin
          if (cur_first) phase_next = scfr_pkg::PH_FIRST;
          else do_drop = 1'b1;
        end
        scfr_pkg::PH_FIRST: begin
          if (cur_second) begin
            clear_skip       = 1'b1;
            hdr_we[0]        = 1'b1;
            running_crc_next = scfr_pkg::CRC_INIT;
            phase_next       = scfr_pkg::PH_CMD;
          end else begin
            do_drop = 1'b1;
            if (!cur_first) phase_next = scfr_pkg::PH_HUNT;
          end
        end
        scfr_pkg::PH_CMD: begin
          hdr_we[1]        = 1'b1;
          running_crc_next = crc_upd;
          phase_next       = scfr_pkg::PH_LEN_LO;
        end
        scfr_pkg::PH_LEN_LO: begin
          hdr_we[2]        = 1'b1;
          running_crc_next = crc_upd;
          phase_next       = scfr_pkg::PH_LEN_HI;
        end
        scfr_pkg::PH_LEN_HI: begin
          hdr_we[3]         = 1'b1;
          running_crc_next  = crc_upd;
          byte_counter_next = '0;
          if ((new_len > cfg.payload_limit) || ((new_len >> LENGTH_BITS) != '0)) begin
            bad_next                = bad_frames + 1'b1;
            res_load                = 1'b1;
            res_next.kind           = scfr_pkg::KIND_BAD;
            res_next.payload_length = new_len;
            res_next.last           = 1'b1;
            do_drop                 = 1'b1;
            replay_start            = 1'b1;
            phase_next              = scfr_pkg::PH_HUNT;
          end else begin
            phase_next = (new_len != '0) ? scfr_pkg::PH_PAYLOAD : scfr_pkg::PH_CRC_LO;
          end
        end
        scfr_pkg::PH_PAYLOAD: begin
          running_crc_next      = crc_upd;
          byte_counter_next     = cnt_inc;
          res_load              = 1'b1;
          res_next.kind         = scfr_pkg::KIND_PAYLOAD;
          res_next.payload_byte = cur_byte;
          if (16'(cnt_inc) >= len) phase_next = scfr_pkg::PH_CRC_LO;
        end
        scfr_pkg::PH_CRC_LO: begin
          crc_low_byte_next = cur_byte;
          phase_next        = scfr_pkg::PH_CRC_HI;
        end
        scfr_pkg::PH_CRC_HI: begin
          res_load      = 1'b1;
          res_next.last = 1'b1;
          if ({cur_byte, crc_low_byte} == running_crc) begin
            good_next     = good_frames + 1'b1;
            res_next.kind = scfr_pkg::KIND_GOOD;
          end else begin
            bad_next      = bad_frames + 1'b1;
            res_next.kind = scfr_pkg::KIND_BAD;
          end
          phase_next = scfr_pkg::PH_HUNT;
        end
        default: phase_next = scfr_pkg::PH_HUNT;
      endcase
    end

    // A dropped byte opens a run unless one is already open
    dropped_next  = dropped_runs + {31'd0, (do_drop && !skipping_flag)};
    skipping_next = clear_skip ? 1'b0 : (skipping_flag || do_drop);

    res_next.good_count    = good_next;
    res_next.bad_count     = bad_next;
    res_next.dropped_count = dropped_next;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < scfr_pkg::REPLAY_BYTES; i++) begin
      if (hdr_we[i]) header_store[i] <= cur_byte;
    end
    if (res_load) out_res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= scfr_pkg::PH_HUNT;
      replay_index  <= '0;
      replay_active <= 1'b0;
      byte_counter  <= '0;
      running_crc   <= scfr_pkg::CRC_INIT;
      crc_low_byte  <= '0;
      skipping_flag <= 1'b0;
      good_frames   <= '0;
      bad_frames    <= '0;
      dropped_runs  <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_counter  <= byte_counter_next;
      running_crc   <= running_crc_next;
      crc_low_byte  <= crc_low_byte_next;
      skipping_flag <= skipping_next;
      good_frames   <= good_next;
      bad_frames    <= bad_next;
      dropped_runs  <= dropped_next;
      if (replay_start) begin
        replay_active <= 1'b1;
        replay_index  <= '0;
      end else if (replay_active) begin
        replay_index <= replay_index + 1'b1;
        if (replay_index == REPLAY_BITS'(scfr_pkg::REPLAY_BYTES - 1)) replay_active <= 1'b0;
      end
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Replay bytes never pull from the queue
  a_replay_no_pop: assert property (@(posedge clk) disable iff (rst)
    replay_active |-> !q_pop)
    else $error("queue popped during header replay");

  // A bad length starts the replay from the first stored header byte
  a_bad_len_replays: assert property (@(posedge clk) disable iff (rst)
    (res_load && phase == scfr_pkg::PH_LEN_HI) |=> (replay_active && replay_index == '0))
    else $error("bad length did not start a replay");

  // Replay lasts exactly four bytes
  a_replay_ends: assert property (@(posedge clk) disable iff (rst)
    (replay_active && replay_index == REPLAY_BITS'(scfr_pkg::REPLAY_BYTES - 1))
      |=> !replay_active)
    else $error("replay ran past the header");

  // Payload phase is only entered with a nonzero declared length
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    (phase == scfr_pkg::PH_PAYLOAD) |-> (len != '0))
    else $error("payload phase with zero length");

endmodule

`default_nettype wire

/* sim/sync_crc16_frame_receiver_test.sv */
// Self-checking testbench for the sync/CRC16 frame receiver: random framed byte streams.
`timescale 1ns / 1ps

module sync_crc16_frame_receiver_test;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 8;
  // Quiet time before a register write or the final verdict, so that the queue
  // empties and any header replay ends, with margin.
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 100;
  localparam int PHASE_BYTES   = 160;
  // Index outside the register map, must be ignored by the block
  localparam logic [1:0] CFG_NO_REG = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = scfr_pkg::CFG_SYNC_FIRST;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  command;
  logic [7:0]  payload_byte;
  logic [15:0] payload_length;
  logic        last;
  logic [31:0] good_count;
  logic [31:0] bad_count;
  logic [31:0] dropped_count;

  sync_crc16_frame_receiver u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .command        (command),
    .payload_byte   (payload_byte),
    .payload_length (payload_length),
    .last           (last),
    .good_count     (good_count),
    .bad_count      (bad_count),
    .dropped_count  (dropped_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Deframer prediction: own copy of the register settings and parser state.
  // Starts in the post-reset state; reset is applied once only.
  // ---------------------------------------------------------------------------
  logic [7:0]  sync_a    = scfr_pkg::SYNC_FIRST_RESET;
  logic [7:0]  sync_b    = scfr_pkg::SYNC_SECOND_RESET;
  logic [15:0] len_limit = scfr_pkg::PAYLOAD_LIMIT_RESET;

  scfr_pkg::phase_t rx_phase = scfr_pkg::PH_HUNT;
  logic [7:0]  hdr_bytes[4] = '{default: 8'h00};  // sync_b, command, len lo, len hi
  logic [15:0] pay_seen    = '0;
  logic [15:0] crc_acc     = scfr_pkg::CRC_INIT;
  logic [7:0]  crc_lo_rcvd = '0;
  logic        drop_open   = 1'b0;
  logic [31:0] n_good      = '0;
  logic [31:0] n_bad       = '0;
  logic [31:0] n_drop      = '0;

  scfr_pkg::result_t pending_results[$];   // predicted result requests, oldest first
  logic [7:0]  link_bytes[$];        // bytes waiting to be offered
  logic [7:0]  body_q[$];            // payload of the frame being built
  int          bytes_taken = 0;
  int          mismatches  = 0;

  // CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ scfr_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  // A skipped byte opens a dropped run unless one is already open
  task automatic open_drop_run();
    if (!drop_open) begin
      n_drop++;
      drop_open = 1'b1;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit made,
                              output scfr_pkg::result_t r, output bit replay);
    logic [15:0] len;
    made   = 1'b0;
    replay = 1'b0;
    r      = '0;
    len    = {hdr_bytes[3], hdr_bytes[2]};
    case (rx_phase)
      scfr_pkg::PH_HUNT: begin
        if (b == sync_a) rx_phase = scfr_pkg::PH_FIRST;
        else open_drop_run();
      end
      scfr_pkg::PH_FIRST: begin
        if (b == sync_b) begin
          drop_open    = 1'b0;
          hdr_bytes[0] = b;
          crc_acc      = scfr_pkg::CRC_INIT;
          rx_phase     = scfr_pkg::PH_CMD;
        end else begin
          // a repeated first marker stays the candidate
          open_drop_run();
          if (b != sync_a) rx_phase = scfr_pkg::PH_HUNT;
        end
      end
      scfr_pkg::PH_CMD: begin
        hdr_bytes[1] = b;
        crc_acc      = crc_next(crc_acc, b);
        rx_phase     = scfr_pkg::PH_LEN_LO;
      end
      scfr_pkg::PH_LEN_LO: begin
        hdr_bytes[2] = b;
        crc_acc      = crc_next(crc_acc, b);
        rx_phase     = scfr_pkg::PH_LEN_HI;
      end
      scfr_pkg::PH_LEN_HI: begin
        hdr_bytes[3] = b;
        crc_acc      = crc_next(crc_acc, b);
        len          = {b, hdr_bytes[2]};
        pay_seen     = '0;
        if (len > len_limit) begin
          // oversize: closes the frame at once, header goes back through the hunt
          n_bad++;
          r.kind           = scfr_pkg::KIND_BAD;
          r.command        = hdr_bytes[1];
          r.payload_length = len;
          r.last           = 1'b1;
          open_drop_run();
          rx_phase = scfr_pkg::PH_HUNT;
          replay   = 1'b1;
          made     = 1'b1;
        end else begin
          rx_phase = (len != 0) ? scfr_pkg::PH_PAYLOAD : scfr_pkg::PH_CRC_LO;
        end
      end
      scfr_pkg::PH_PAYLOAD: begin
        crc_acc          = crc_next(crc_acc, b);
        pay_seen         = pay_seen + 16'd1;
        r.kind           = scfr_pkg::KIND_PAYLOAD;
        r.command        = hdr_bytes[1];
        r.payload_byte   = b;
        r.payload_length = len;
        made             = 1'b1;
        if (pay_seen >= len) rx_phase = scfr_pkg::PH_CRC_LO;
      end
      scfr_pkg::PH_CRC_LO: begin
        crc_lo_rcvd = b;
        rx_phase    = scfr_pkg::PH_CRC_HI;
      end
      default: begin
        if ({b, crc_lo_rcvd} == crc_acc) begin
          n_good++;
          r.kind = scfr_pkg::KIND_GOOD;
        end else begin
          n_bad++;
          r.kind = scfr_pkg::KIND_BAD;
        end
        r.command        = hdr_bytes[1];
        r.payload_length = len;
        r.last           = 1'b1;
        rx_phase         = scfr_pkg::PH_HUNT;
        made             = 1'b1;
      end
    endcase
  endtask

  // Full effect of one accepted byte, including the header replay
  task automatic track_rx_byte(input logic [7:0] b);
    bit                made, replay, spare_made, spare_replay;
    scfr_pkg::result_t r, spare;
    logic [7:0]        saved[4];
    deframe_byte(b, made, r, replay);
    if (replay) begin
      saved = hdr_bytes;
      for (int i = 0; i < 4; i++) deframe_byte(saved[i], spare_made, spare, spare_replay);
    end
    if (made) begin
      // counters as they stand after the replay
      r.good_count    = n_good;
      r.bad_count     = n_bad;
      r.dropped_count = n_drop;
      pending_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender: bursts of random length, random gaps between them.
  // in_valid gets exactly one NBA per edge so a held request never blips.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_rx_byte(rx_byte);
        bytes_taken++;
      end
      offer = in_valid && !in_ready;   // request still waiting, payload held
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (link_bytes.size() != 0) begin
          rx_byte <= link_bytes.pop_front();
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall mode is redrawn whenever the low bits of the cycle count wrap; long hold-offs at
  // set byte counts let the input queue fill and back-pressure the sender.
  // ---------------------------------------------------------------------------
  logic [31:0] stall_cyc    = '0;
  int          stall_mode   = 0;
  int          hold_left    = 0;
  int          next_hold_at = 300;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    scfr_pkg::result_t want;
    logic              go;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result request with nothing expected: kind %0h", kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("command", want.command, command);
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("payload_length", want.payload_length, payload_length);
          check_field("last", want.last, last);
          check_field("good_count", want.good_count, good_count);
          check_field("bad_count", want.bad_count, bad_count);
          check_field("dropped_count", want.dropped_count, dropped_count);
        end
      end
      stall_cyc++;
      if (stall_cyc[5:0] == 6'd0) stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        go = 1'b0;
      end else if (bytes_taken >= next_hold_at) begin
        hold_left    = LONG_HOLD;
        next_hold_at = next_hold_at + 350;
        go           = 1'b0;
      end else begin
        case (stall_mode)
          0:       go = 1'b1;                        // no stalls
          1:       go = 1'($urandom_range(0, 1));
          2:       go = (stall_cyc[1:0] != 2'd0);
          default: go = !stall_cyc[3];               // stall windows from bit 3 of the cycle count
        endcase
      end
      out_ready <= go;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  // Sync pair, command, length, then body_q and CRC; an oversize length gets
  // the header only, since the block drops the frame there.
  task automatic queue_frame(input logic [7:0] cmd, input logic [15:0] len,
                             input logic [15:0] crc_flip);
    logic [15:0] crc;
    link_bytes.push_back(sync_a);
    link_bytes.push_back(sync_b);
    link_bytes.push_back(cmd);
    link_bytes.push_back(len[7:0]);
    link_bytes.push_back(len[15:8]);
    if (len > len_limit) return;
    crc = crc_next(crc_next(crc_next(scfr_pkg::CRC_INIT, cmd), len[7:0]), len[15:8]);
    foreach (body_q[i]) begin
      link_bytes.push_back(body_q[i]);
      crc = crc_next(crc, body_q[i]);
    end
    crc = crc ^ crc_flip;
    link_bytes.push_back(crc[7:0]);
    link_bytes.push_back(crc[15:8]);
  endtask

  // Mostly well-formed frames with random content; some noise in front,
  // some oversize lengths, some bad CRCs and a few cut-off headers.
  task automatic queue_random_frame();
    int          pick, len, top;
    logic [15:0] flip;
    pick = $urandom_range(0, 99);
    body_q.delete();
    if (pick < 20) repeat ($urandom_range(1, 3)) link_bytes.push_back(8'($urandom));
    // cut-off header; kept to small limits so a bogus length cannot swallow the phase
    if (pick >= 92 && len_limit <= 16'd256) begin
      link_bytes.push_back(sync_a);
      link_bytes.push_back(sync_b);
      repeat ($urandom_range(0, 2)) link_bytes.push_back(8'($urandom));
      return;
    end
    if (pick >= 84 && len_limit != 16'hFFFF) begin
      len = int'(len_limit) + 1 + int'($urandom_range(0, 300));
      if (len > 65535) len = 65535;
    end else begin
      top = (pick < 8) ? 64 : 10;
      if (top > int'(len_limit)) top = int'(len_limit);
      len = $urandom_range(0, top);
      repeat (len) body_q.push_back(8'($urandom));
    end
    flip = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
    queue_frame(8'($urandom), 16'(len), flip);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      scfr_pkg::CFG_SYNC_FIRST:    sync_a    = val[7:0];
      scfr_pkg::CFG_SYNC_SECOND:   sync_b    = val[7:0];
      scfr_pkg::CFG_PAYLOAD_LIMIT: len_limit = val;
      default: ;
    endcase
  endtask

  // Sender pause: wait for every queued byte to go and every result to come,
  // then let the parser finish any header replay.
  task automatic drain();
    while (link_bytes.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // New register set while idle (sync writes carry junk in the upper byte),
  // then a stretch of random frames.
  task automatic run_phase(input logic [7:0] s1, input logic [7:0] s2,
                           input logic [15:0] lim);
    int phase_bytes, n0;
    phase_bytes = 0;
    write_reg(scfr_pkg::CFG_SYNC_FIRST, {8'($urandom), s1});
    write_reg(scfr_pkg::CFG_SYNC_SECOND, {8'($urandom), s2});
    write_reg(scfr_pkg::CFG_PAYLOAD_LIMIT, lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    while (phase_bytes < PHASE_BYTES) begin
      n0 = link_bytes.size();
      queue_random_frame();
      phase_bytes += link_bytes.size() - n0;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values.
    // Junk bytes 00/FF open a dropped run; a doubled first marker keeps the newest.
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(scfr_pkg::SYNC_FIRST_RESET);
    // zero-length frame, CRC straight after the length, good
    body_q.delete();
    queue_frame(8'hFF, 16'd0, 16'h0000);
    // payload extremes with a broken CRC
    body_q = '{8'h00, 8'hFF};
    queue_frame(8'h00, 16'd2, 16'h8001);
    // length just past the limit: bad frame, header replayed
    body_q.delete();
    queue_frame(8'h07, scfr_pkg::PAYLOAD_LIMIT_RESET + 16'd2, 16'h0000);
    drain();

    // A write outside the register map must change nothing
    write_reg(CFG_NO_REG, 16'($urandom));
    run_phase(8'h00, 8'hFF, 16'h0000);       // only zero-length frames pass
    run_phase(8'hFF, 8'h00, 16'hFFFF);       // no length is oversize
    run_phase(8'h7E, 8'h7E, 16'd5);          // identical markers
    run_phase(8'($urandom), 8'($urandom), 16'd16);
    run_phase(scfr_pkg::SYNC_FIRST_RESET, scfr_pkg::SYNC_SECOND_RESET,
              scfr_pkg::PAYLOAD_LIMIT_RESET);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #(CLK_PERIOD * 400000);
    $display("Verification failed");
    $finish;
  end

endmodule

/* sync_crc16_frame_receiver.f */
rtl/scfr_pkg.sv
rtl/scfr_rx_queue.sv
rtl/scfr_parser.sv
rtl/sync_crc16_frame_receiver.sv
sim/sync_crc16_frame_receiver_test.sv
